// ----- design/i2cwb_pkg.sv -----
`timescale 1ns / 1ps

package i2cwb_pkg;

	localparam int HOLD_W   = 16;
	localparam int DATA_W   = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [HOLD_W-1:0] SETUP_HOLD_RESET  = HOLD_W'(10);
	localparam logic [HOLD_W-1:0] HALF_PERIOD_RESET = HOLD_W'(500);

	localparam logic [CFG_IDX_W-1:0] REG_SETUP_HOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(1);

	// data bits 0..7, then the fake ACK slot
	localparam int BIT_CNT_W = 4;
	localparam logic [BIT_CNT_W-1:0] ACK_SLOT = BIT_CNT_W'(DATA_W);

	typedef struct packed {
		logic [HOLD_W-1:0] setup_hold;
		logic [HOLD_W-1:0] half_period;
	} cfg_t;

	typedef struct packed {
		logic              scl;
		logic              sda;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} phase_t;

endpackage

// ----- design/i2c_write_only_bit_shifter.sv -----
`timescale 1ns / 1ps
// Write-only I2C master phase generator for a target that never acknowledges.
// Input channel (in_valid/in_ready): one byte plus start_before/stop_after.
// Output channel (out_valid/out_ready): one pin phase per transfer, giving the
// SCL and SDA levels and how long to hold them; last_phase marks the final
// phase of a byte. A byte yields 27 phases, plus 4 for a start and 4 for a stop.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 is the setup hold,
// index 1 the half period, both in microseconds; other indexes are ignored.
// The first phase of a byte passes from the registered sequencer state into the
// output register before it shows on the output, when that register is free.
// Throughput: one phase per cycle while the receiver is ready; a byte gives 27
// to 35 phases as the phase sequencer steps through start, bits, ACK slot and
// stop. The next byte is taken in the cycle its predecessor's last phase enters
// the output register, so phases of consecutive bytes follow without a gap.
// Reset: pins assumed low, setup hold 10, half period 500, no pending work.
// When the receiver stalls, the output register holds its phase and the
// sequencer waits; input is refused until the last phase is loaded there.
module i2c_write_only_bit_shifter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [i2cwb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cwb_pkg::HOLD_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [i2cwb_pkg::DATA_W-1:0]    data_byte,
	input  logic                            start_before,
	input  logic                            stop_after,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            scl_level,
	output logic                            sda_level,
	output logic [i2cwb_pkg::HOLD_W-1:0]    hold_us,
	output logic                            last_phase
);
	import i2cwb_pkg::*;

	cfg_t   cfg;
	phase_t phase;
	logic   phase_valid;
	logic   take;

	i2cwb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cwb_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.start_before (start_before),
		.stop_after   (stop_after),
		.cfg          (cfg),
		.take         (take),
		.phase_valid  (phase_valid),
		.phase        (phase)
	);

	i2cwb_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_valid (phase_valid),
		.phase       (phase),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_level   (scl_level),
		.sda_level   (sda_level),
		.hold_us     (hold_us),
		.last_phase  (last_phase)
	);

endmodule

// ----- design/i2cwb_cfg_regs.sv -----
`timescale 1ns / 1ps

module i2cwb_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [i2cwb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cwb_pkg::HOLD_W-1:0]  cfg_data,
	output i2cwb_pkg::cfg_t               cfg
);
	import i2cwb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setup_hold  <= SETUP_HOLD_RESET;
			cfg_q.half_period <= HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			// unknown indexes are dropped
			unique case (cfg_index)
				REG_SETUP_HOLD:  cfg_q.setup_hold  <= cfg_data;
				REG_HALF_PERIOD: cfg_q.half_period <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/i2cwb_seq.sv -----
`timescale 1ns / 1ps

module i2cwb_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [i2cwb_pkg::DATA_W-1:0] data_byte,
	input  logic                         start_before,
	input  logic                         stop_after,
	input  i2cwb_pkg::cfg_t              cfg,
	input  logic                         take,
	output logic                         phase_valid,
	output i2cwb_pkg::phase_t            phase
);
	import i2cwb_pkg::*;

	typedef enum logic [1:0] {
		SEG_START,
		SEG_BITS,
		SEG_STOP
	} seg_t;

	seg_t                 seg_q;
	logic [1:0]           step_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic                 busy_q;
	logic [DATA_W-1:0]    data_q;
	logic                 stop_q;
	logic                 scl_pin_q;
	logic                 sda_pin_q;

	logic issue;
	logic accept;
	logic cur_bit;
	logic [2:0] bit_idx;

	assign bit_idx = 3'(DATA_W - 1) - bit_q[2:0];
	assign cur_bit = (bit_q == ACK_SLOT) ? 1'b1 : data_q[bit_idx];

	always_comb begin
		phase.scl  = scl_pin_q;
		phase.sda  = sda_pin_q;
		phase.hold = cfg.half_period;
		phase.last = 1'b0;
		unique case (seg_q)
			SEG_START: begin
				case (step_q)
					2'd0: phase.scl = 1'b1;
					2'd1: begin
						phase.scl = 1'b1;
						phase.sda = 1'b1;
					end
					2'd2: begin
						phase.scl = 1'b1;
						phase.sda = 1'b0;
					end
					default: begin
						phase.scl = 1'b0;
						phase.sda = 1'b0;
					end
				endcase
			end
			SEG_BITS: begin
				phase.sda = cur_bit;
				case (step_q)
					2'd0: phase.hold = cfg.setup_hold;
					2'd1: phase.scl = 1'b1;
					default: phase.scl = 1'b0;
				endcase
				phase.last = (bit_q == ACK_SLOT) && (step_q == 2'd2) && !stop_q;
			end
			SEG_STOP: begin
				case (step_q)
					2'd0: phase.scl = 1'b0;
					2'd1: begin
						phase.scl = 1'b0;
						phase.sda = 1'b0;
					end
					2'd2: begin
						phase.scl = 1'b1;
						phase.sda = 1'b0;
					end
					default: begin
						phase.scl  = 1'b1;
						phase.sda  = 1'b1;
						phase.last = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign phase_valid = busy_q;
	assign issue       = busy_q && take;
	// next byte may load while the final phase of this one is handed off
	assign in_ready    = !busy_q || (issue && phase.last);
	assign accept      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= SEG_START;
			step_q    <= 2'd0;
			bit_q     <= '0;
			busy_q    <= 1'b0;
			stop_q    <= 1'b0;
			scl_pin_q <= 1'b0;
			sda_pin_q <= 1'b0;
		end else begin
			if (issue) begin
				scl_pin_q <= phase.scl;
				sda_pin_q <= phase.sda;
			end
			if (accept) begin
				busy_q <= 1'b1;
				stop_q <= stop_after;
				seg_q  <= start_before ? SEG_START : SEG_BITS;
				step_q <= 2'd0;
				bit_q  <= '0;
			end else if (issue && phase.last) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				unique case (seg_q)
					SEG_START: begin
						if (step_q == 2'd3) begin
							seg_q  <= SEG_BITS;
							step_q <= 2'd0;
							bit_q  <= '0;
						end else begin
							step_q <= step_q + 2'd1;
						end
					end
					SEG_BITS: begin
						if (step_q == 2'd2) begin
							step_q <= 2'd0;
							if (bit_q == ACK_SLOT) begin
								seg_q <= SEG_STOP;
							end else begin
								bit_q <= bit_q + BIT_CNT_W'(1);
							end
						end else begin
							step_q <= step_q + 2'd1;
						end
					end
					SEG_STOP: step_q <= step_q + 2'd1;
					default: seg_q <= SEG_START;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= data_byte;
		end
	end

endmodule

// ----- design/i2cwb_out_reg.sv -----
`timescale 1ns / 1ps

module i2cwb_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         phase_valid,
	input  i2cwb_pkg::phase_t            phase,
	output logic                         take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         scl_level,
	output logic                         sda_level,
	output logic [i2cwb_pkg::HOLD_W-1:0] hold_us,
	output logic                         last_phase
);
	import i2cwb_pkg::*;

	logic   out_valid_q;
	phase_t phase_q;

	assign take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= phase_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && phase_valid) begin
			phase_q <= phase;
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = phase_q.scl;
	assign sda_level  = phase_q.sda;
	assign hold_us    = phase_q.hold;
	assign last_phase = phase_q.last;

endmodule

// ----- design/i2cwb_checker.sv -----
`timescale 1ns / 1ps

module i2cwb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         scl_level,
	input logic                         sda_level,
	input logic [i2cwb_pkg::HOLD_W-1:0] hold_us,
	input logic                         last_phase
);
	import i2cwb_pkg::*;

	// stalled result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(sda_level)
			&& $stable(hold_us) && $stable(last_phase))
		else $error("stalled phase changed");

	// phases of one byte follow each other without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_phase |=> out_valid)
		else $error("gap inside a byte's phase sequence");

	// no new byte while a byte's phases are stuck mid-sequence
	a_no_accept_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !last_phase |-> !in_ready)
		else $error("input taken while a byte is still in flight");

	// a byte taken on an empty output shows its first phase after the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("first phase late");

endmodule

bind i2c_write_only_bit_shifter i2cwb_checker u_i2cwb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.scl_level  (scl_level),
	.sda_level  (sda_level),
	.hold_us    (hold_us),
	.last_phase (last_phase)
);

// ----- tb/i2c_write_only_bit_shifter_check.sv -----
`timescale 1ns / 1ps

module i2c_write_only_bit_shifter_check
	import i2cwb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HOLD_W-1:0] cfg_data,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [DATA_W-1:0] data_byte,
	input  logic              start_before,
	input  logic              stop_after,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              scl_level,
	input  logic              sda_level,
	input  logic [HOLD_W-1:0] hold_us,
	input  logic              last_phase,
	output int                errors,
	output int                pending,
	output int                phases_checked
);

	cfg_t   timing;
	logic   scl_pin;
	logic   sda_pin;
	phase_t pin_phases_due[$];
	phase_t want;
	int     phase_idx;
	int     phase_total;

	function void emit_phase(input logic [HOLD_W-1:0] hold);
		phase_t p;
		p.scl  = scl_pin;
		p.sda  = sda_pin;
		p.hold = hold;
		p.last = (phase_idx == phase_total - 1);
		pin_phases_due.push_back(p);
		phase_idx++;
	endfunction

	function void pulse_scl(input logic sda_val);
		sda_pin = sda_val;
		emit_phase(timing.setup_hold);
		scl_pin = 1'b1;
		emit_phase(timing.half_period);
		scl_pin = 1'b0;
		emit_phase(timing.half_period);
	endfunction

	// pin phases for one byte: optional start, 8 bits MSB first, fake ACK, optional stop
	function void expand_byte(input logic [DATA_W-1:0] value, input logic with_start,
			input logic with_stop);
		phase_idx = 0;
		phase_total = 3 * (DATA_W + 1) + (with_start ? 4 : 0) + (with_stop ? 4 : 0);
		if (with_start) begin
			scl_pin = 1'b1;
			emit_phase(timing.half_period);
			sda_pin = 1'b1;
			emit_phase(timing.half_period);
			sda_pin = 1'b0;
			emit_phase(timing.half_period);
			scl_pin = 1'b0;
			emit_phase(timing.half_period);
		end
		for (int i = DATA_W - 1; i >= 0; i--)
			pulse_scl(value[i]);
		pulse_scl(1'b1);
		if (with_stop) begin
			scl_pin = 1'b0;
			emit_phase(timing.half_period);
			sda_pin = 1'b0;
			emit_phase(timing.half_period);
			scl_pin = 1'b1;
			emit_phase(timing.half_period);
			sda_pin = 1'b1;
			emit_phase(timing.half_period);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing.setup_hold  = SETUP_HOLD_RESET;
			timing.half_period = HALF_PERIOD_RESET;
			scl_pin = 1'b0;
			sda_pin = 1'b0;
			pin_phases_due.delete();
			errors = 0;
			pending = 0;
			phases_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SETUP_HOLD:  timing.setup_hold = cfg_data;
					REG_HALF_PERIOD: timing.half_period = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pin_phases_due.size() == 0) begin
					errors++;
					$error("phase transfer with nothing expected: scl %0b sda %0b hold %0d last %0b",
						scl_level, sda_level, hold_us, last_phase);
				end else begin
					want = pin_phases_due.pop_front();
					phases_checked++;
					if (scl_level !== want.scl) begin
						errors++;
						$error("scl_level: expected %0b, got %0b", want.scl, scl_level);
					end
					if (sda_level !== want.sda) begin
						errors++;
						$error("sda_level: expected %0b, got %0b", want.sda, sda_level);
					end
					if (hold_us !== want.hold) begin
						errors++;
						$error("hold_us: expected %0d, got %0d", want.hold, hold_us);
					end
					if (last_phase !== want.last) begin
						errors++;
						$error("last_phase: expected %0b, got %0b", want.last, last_phase);
					end
				end
			end
			if (in_valid && in_ready)
				expand_byte(data_byte, start_before, stop_after);
			pending = pin_phases_due.size();
		end
	end

endmodule

// ----- tb/i2c_write_only_bit_shifter_test.sv -----
`timescale 1ns / 1ps

module i2c_write_only_bit_shifter_test;
	import i2cwb_pkg::*;

	localparam int IDLE_PCT     = 27;
	localparam int HOLD_OFF     = 300;
	localparam int CHUNK_ITEMS  = 50;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_HALF_PERIOD + CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

	localparam logic [DATA_W-1:0] CTRL_DATA = 8'h40;
	localparam logic [DATA_W-1:0] CTRL_CMD  = 8'h00;

	// {byte, start, stop}
	localparam int NUM_DIRECTED = 14;
	localparam logic [DATA_W+1:0] DIRECTED [NUM_DIRECTED] = '{
		{8'h00, 1'b1, 1'b0},
		{8'hFF, 1'b0, 1'b0},
		{8'h80, 1'b0, 1'b1},
		{8'h01, 1'b0, 1'b0},   // pins left high by the stop
		{8'hAA, 1'b1, 1'b1},   // repeated start
		{8'h55, 1'b1, 1'b0},
		{CTRL_DATA, 1'b0, 1'b0},
		{CTRL_CMD, 1'b0, 1'b1},
		{8'h78, 1'b1, 1'b0},
		{8'h7F, 1'b0, 1'b0},
		{8'hFE, 1'b0, 1'b1},
		{8'h3C, 1'b1, 1'b1},
		{8'hFF, 1'b0, 1'b1},
		{8'h00, 1'b1, 1'b1}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HOLD_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [DATA_W-1:0]    data_byte;
	logic                 start_before;
	logic                 stop_after;
	logic                 out_valid;
	logic                 out_ready;
	logic                 scl_level;
	logic                 sda_level;
	logic [HOLD_W-1:0]    hold_us;
	logic                 last_phase;

	int mismatches;
	int phases_pending;
	int phases_checked;
	int bytes_sent;
	int reg_writes;
	int cycles;
	int stall_asks;
	bit steady;

	always #1 clk = ~clk;

	i2c_write_only_bit_shifter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.start_before(start_before), .stop_after(stop_after),
		.out_valid(out_valid), .out_ready(out_ready), .scl_level(scl_level),
		.sda_level(sda_level), .hold_us(hold_us), .last_phase(last_phase)
	);

	i2c_write_only_bit_shifter_check checker_i (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.start_before(start_before), .stop_after(stop_after),
		.out_valid(out_valid), .out_ready(out_ready), .scl_level(scl_level),
		.sda_level(sda_level), .hold_us(hold_us), .last_phase(last_phase),
		.errors(mismatches), .pending(phases_pending), .phases_checked(phases_checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// phase receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int stall_left;
		int stalls_taken;
		stall_left = 0;
		stalls_taken = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stalls_taken != stall_asks) begin
				stalls_taken = stall_asks;
				stall_left = HOLD_OFF;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_byte(input logic [DATA_W-1:0] value, input logic with_start,
			input logic with_stop);
		int gap;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= value;
		start_before <= with_start;
		stop_after   <= with_stop;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// address with start, control byte, payload, stop on the final byte
	task automatic send_transaction();
		int n;
		n = $urandom_range(1, 6);
		send_byte(DATA_W'($urandom), 1'b1, 1'b0);
		send_byte($urandom_range(1) ? CTRL_DATA : CTRL_CMD, 1'b0, 1'b0);
		for (int k = 0; k < n; k++)
			send_byte(DATA_W'($urandom), 1'b0, k == n - 1);
	endtask

	task automatic run_traffic(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			if ($urandom_range(99) < 80)
				send_transaction();
			else
				send_byte(DATA_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
		end
	endtask

	// drop valid and wait for every expected phase to drain
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (phases_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		data_byte    = '0;
		start_before = 1'b0;
		stop_after   = 1'b0;
		cycles       = 0;
		bytes_sent   = 0;
		reg_writes   = 0;
		stall_asks   = 0;
		steady       = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing
		for (int i = 0; i < NUM_DIRECTED; i++)
			send_byte(DIRECTED[i][DATA_W+1:2], DIRECTED[i][1], DIRECTED[i][0]);
		settle();

		// zero holds pass straight through
		write_reg(REG_SETUP_HOLD, '0);
		write_reg(REG_HALF_PERIOD, '0);
		cfg_valid <= 1'b0;
		run_traffic(CHUNK_ITEMS);
		settle();

		// max holds, writes to unused indexes must not land; no idling on either side
		write_reg(REG_SETUP_HOLD, '1);
		write_reg(REG_HALF_PERIOD, '1);
		write_reg(REG_FIRST_UNUSED, HOLD_W'($urandom));
		write_reg(REG_LAST_UNUSED, HOLD_W'($urandom));
		cfg_valid <= 1'b0;
		steady = 1'b1;
		run_traffic(CHUNK_ITEMS);
		settle();
		steady = 1'b0;

		// long receiver hold-off while bytes keep coming
		write_reg(REG_SETUP_HOLD, HOLD_W'($urandom_range(1, 65534)));
		write_reg(REG_HALF_PERIOD, HOLD_W'(1));
		cfg_valid <= 1'b0;
		stall_asks++;
		run_traffic(CHUNK_ITEMS);
		settle();

		write_reg(REG_SETUP_HOLD, HOLD_W'($urandom));
		write_reg(REG_HALF_PERIOD, HOLD_W'($urandom));
		cfg_valid <= 1'b0;
		run_traffic(CHUNK_ITEMS);
		settle();

		write_reg(REG_HALF_PERIOD, HOLD_W'($urandom));
		write_reg(REG_SETUP_HOLD, '1);
		cfg_valid <= 1'b0;
		run_traffic(CHUNK_ITEMS);
		settle();

		repeat (8) @(posedge clk);
		$display("Covered %0d bytes over 6 timing setups (holds at 0 and 65535, unused indexes),",
			bytes_sent);
		$display("%0d register writes, %0d pin phases compared, one %0d-cycle output hold-off.",
			reg_writes, phases_checked, HOLD_OFF);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
